@@ design/tar_pkg.sv @@
// shared types and constants for the tetrahedron squared aspect ratio core
// no dependencies; used by tar_geom, tar_div_cell and the top level
package tar_pkg;

    // input coordinate and fixed-point output format
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int RATIO_W    = 48;

    // datapath widths, sized for the worst case coordinates
    localparam int DIFF_W  = COORD_BITS + 1;      // coordinate difference
    localparam int PROD_W  = 2 * DIFF_W;          // difference times difference
    localparam int LEN_W   = PROD_W + 1;          // squared edge length
    localparam int NRM_W   = PROD_W + 1;          // normal component, signed
    localparam int ABS_W   = NRM_W - 1;           // normal component magnitude
    localparam int NSQ_W   = 2 * ABS_W;           // normal component squared
    localparam int N2_W    = NSQ_W + 2;           // squared normal length
    localparam int WP_W    = DIFF_W + NRM_W;      // w times n product
    localparam int DP_W    = WP_W + 2;            // triple product, signed
    localparam int ADP_W   = DP_W - 2;            // triple product magnitude
    localparam int DHALF_W = ADP_W / 2;           // split of |dp| for squaring
    localparam int NHALF_W = N2_W / 2;            // split of nmax
    localparam int PL_W    = LEN_W + NHALF_W;     // lmax times one half of nmax
    localparam int PD_W    = 2 * DHALF_W;         // one partial of dp squared
    localparam int NUM_W   = LEN_W + N2_W + FRAC_BITS + 1;
    localparam int DEN_W   = 2 * ADP_W + 2;
    localparam int QUO_W   = RATIO_W;
    localparam int CMP_W   = DEN_W + QUO_W;

    localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

    // one input item
    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] az;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] bz;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] cz;
        logic signed [COORD_BITS-1:0] dx;
        logic signed [COORD_BITS-1:0] dy;
        logic signed [COORD_BITS-1:0] dz;
    } t_tet_in;

    // one result item
    typedef struct packed {
        logic [RATIO_W-1:0] ratio_sq;
        logic               degenerate;
    } t_tet_out;

    // data handed from one divider cell to the next
    typedef struct packed {
        logic             valid;
        logic             sat;
        logic             deg;
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } t_div_stage;

endpackage

@@ design/tet_aspect_ratio_squared_core.sv @@
// top level of the tetrahedron squared aspect ratio core
// depends on tar_pkg, tar_geom and tar_div_cell
//
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+-----------------------------
//  input    | i_valid  | o_stall  | i_item (four vertices)
//  output   | o_valid  | i_stall  | o_item (ratio_sq, degenerate)
//
// one item per cycle while o_stall is low; 9 geometry stages, 48 divider cells
// (one quotient bit each) and the output register.
// the whole pipeline holds while a result waits under stall; all stages keep
// moving otherwise, bubbles included.
// reset clears only the valid bits; no clearing pass.
module tet_aspect_ratio_squared_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  tar_pkg::t_tet_in  i_item,
    output logic              o_valid,
    input  logic              i_stall,
    output tar_pkg::t_tet_out o_item
);
    import tar_pkg::*;

    t_div_stage w_chain [QUO_W+1];
    logic       w_en;
    logic       r_out_valid;
    t_tet_out   r_out;

    // pipeline advances unless a finished item is held
    assign o_stall = r_out_valid & i_stall;
    assign w_en    = ~o_stall;

    tar_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_stage (w_chain[0])
    );

    // row of divider cells, most significant quotient bit first
    for (genvar j = 0; j < QUO_W; j++) begin : g_cell
        tar_div_cell #(
            .SHIFT (QUO_W - 1 - j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_chain[j]),
            .o_stage (w_chain[j+1])
        );
    end

    // output register with saturation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_chain[QUO_W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.ratio_sq   <= w_chain[QUO_W].sat ? RATIO_MAX : w_chain[QUO_W].quo;
            r_out.degenerate <= w_chain[QUO_W].deg;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

@@ design/tar_geom.sv @@
// geometry front end: edges, face normals, triple product, numerator and denominator
// depends on tar_pkg; feeds the divider cell row
module tar_geom (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  tar_pkg::t_tet_in    i_item,
    output tar_pkg::t_div_stage o_stage
);
    import tar_pkg::*;

    localparam int NSTG = 9;
    localparam int EA [6] = '{0, 0, 0, 1, 1, 2};
    localparam int EB [6] = '{1, 2, 3, 2, 3, 3};
    localparam int FO [4] = '{1, 2, 3, 0};
    localparam int FS [4] = '{2, 3, 0, 1};
    localparam int FT [4] = '{3, 0, 1, 2};
    localparam int C1 [3] = '{1, 2, 0};
    localparam int C2 [3] = '{2, 0, 1};

    logic signed [COORD_BITS-1:0] p [4][3];

    logic [NSTG-1:0] r_vld;

    // stage 1 registers
    logic signed [DIFF_W-1:0] r_ed [6][3];
    logic signed [DIFF_W-1:0] r_e1 [4][3];
    logic signed [DIFF_W-1:0] r_e2 [4][3];
    logic signed [DIFF_W-1:0] r_w1 [3];
    // stage 2 registers
    logic [PROD_W-1:0]        r_esq [6][3];
    logic signed [PROD_W-1:0] r_pp  [4][3][2];
    logic signed [DIFF_W-1:0] r_w2  [3];
    // stage 3 registers
    logic [LEN_W-1:0]         r_len [6];
    logic signed [NRM_W-1:0]  r_n   [4][3];
    logic signed [DIFF_W-1:0] r_w3  [3];
    // stage 4 registers
    logic [LEN_W-1:0]         r_lmax4;
    logic [NSQ_W-1:0]         r_nsq [4][3];
    logic signed [WP_W-1:0]   r_wn  [3];
    // stage 5 registers
    logic [LEN_W-1:0]         r_lmax5;
    logic [N2_W-1:0]          r_n2  [4];
    logic signed [DP_W-1:0]   r_dp;
    // stage 6 registers
    logic [LEN_W-1:0]         r_lmax6;
    logic [N2_W-1:0]          r_nmax;
    logic [ADP_W-1:0]         r_adp;
    logic                     r_deg6;
    // stage 7 registers
    logic [PL_W-1:0]          r_pl;
    logic [PL_W-1:0]          r_ph;
    logic [PD_W-1:0]          r_sl;
    logic [PD_W-1:0]          r_sm;
    logic [PD_W-1:0]          r_sh;
    logic                     r_deg7;
    // stage 8 registers
    logic [NUM_W-1:0]         r_num8;
    logic [DEN_W-1:0]         r_den8;
    logic                     r_deg8;
    // stage 9 registers
    logic [NUM_W-1:0]         r_num9;
    logic [DEN_W-1:0]         r_den9;
    logic                     r_deg9;
    logic                     r_sat9;

    logic [ABS_W-1:0] w_nabs [4][3];
    logic [LEN_W-1:0] w_lmax;
    logic [N2_W-1:0]  w_nmax;

    // vertex table from the item
    always_comb begin
        p[0][0] = i_item.ax; p[0][1] = i_item.ay; p[0][2] = i_item.az;
        p[1][0] = i_item.bx; p[1][1] = i_item.by; p[1][2] = i_item.bz;
        p[2][0] = i_item.cx; p[2][1] = i_item.cy; p[2][2] = i_item.cz;
        p[3][0] = i_item.dx; p[3][1] = i_item.dy; p[3][2] = i_item.dz;
    end

    // valid bits follow the items through the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // stage 1: edge and face differences
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int e = 0; e < 6; e++) begin
                for (int k = 0; k < 3; k++) begin
                    r_ed[e][k] <= DIFF_W'(p[EA[e]][k]) - DIFF_W'(p[EB[e]][k]);
                end
            end
            for (int f = 0; f < 4; f++) begin
                for (int k = 0; k < 3; k++) begin
                    r_e1[f][k] <= DIFF_W'(p[FO[f]][k]) - DIFF_W'(p[FS[f]][k]);
                    r_e2[f][k] <= DIFF_W'(p[FO[f]][k]) - DIFF_W'(p[FT[f]][k]);
                end
            end
            for (int k = 0; k < 3; k++) begin
                r_w1[k] <= DIFF_W'(p[0][k]) - DIFF_W'(p[1][k]);
            end
        end
    end

    // stage 2: squared edge components and cross product partials
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int e = 0; e < 6; e++) begin
                for (int k = 0; k < 3; k++) begin
                    r_esq[e][k] <= PROD_W'(r_ed[e][k]) * PROD_W'(r_ed[e][k]);
                end
            end
            for (int f = 0; f < 4; f++) begin
                for (int c = 0; c < 3; c++) begin
                    r_pp[f][c][0] <= PROD_W'(r_e1[f][C1[c]]) * PROD_W'(r_e2[f][C2[c]]);
                    r_pp[f][c][1] <= PROD_W'(r_e1[f][C2[c]]) * PROD_W'(r_e2[f][C1[c]]);
                end
            end
            r_w2 <= r_w1;
        end
    end

    // stage 3: edge lengths and face normals
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int e = 0; e < 6; e++) begin
                r_len[e] <= LEN_W'(r_esq[e][0]) + LEN_W'(r_esq[e][1]) + LEN_W'(r_esq[e][2]);
            end
            for (int f = 0; f < 4; f++) begin
                for (int c = 0; c < 3; c++) begin
                    r_n[f][c] <= NRM_W'(r_pp[f][c][0]) - NRM_W'(r_pp[f][c][1]);
                end
            end
            r_w3 <= r_w2;
        end
    end

    // longest edge and normal magnitudes
    always_comb begin
        w_lmax = r_len[0];
        for (int e = 1; e < 6; e++) begin
            if (r_len[e] > w_lmax) begin
                w_lmax = r_len[e];
            end
        end
        for (int f = 0; f < 4; f++) begin
            for (int c = 0; c < 3; c++) begin
                w_nabs[f][c] = r_n[f][c][NRM_W-1] ? ABS_W'(-r_n[f][c]) : ABS_W'(r_n[f][c]);
            end
        end
    end

    // stage 4: normal component squares and triple product partials
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lmax4 <= w_lmax;
            for (int f = 0; f < 4; f++) begin
                for (int c = 0; c < 3; c++) begin
                    r_nsq[f][c] <= NSQ_W'(w_nabs[f][c]) * NSQ_W'(w_nabs[f][c]);
                end
            end
            for (int c = 0; c < 3; c++) begin
                r_wn[c] <= WP_W'(r_w3[c]) * WP_W'(r_n[0][c]);
            end
        end
    end

    // stage 5: squared normal lengths and triple product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lmax5 <= r_lmax4;
            for (int f = 0; f < 4; f++) begin
                r_n2[f] <= N2_W'(r_nsq[f][0]) + N2_W'(r_nsq[f][1]) + N2_W'(r_nsq[f][2]);
            end
            r_dp <= DP_W'(r_wn[0]) + DP_W'(r_wn[1]) + DP_W'(r_wn[2]);
        end
    end

    // largest face normal
    always_comb begin
        w_nmax = r_n2[0];
        for (int f = 1; f < 4; f++) begin
            if (r_n2[f] > w_nmax) begin
                w_nmax = r_n2[f];
            end
        end
    end

    // stage 6: maxima, triple product magnitude, flat check
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lmax6 <= r_lmax5;
            r_nmax  <= w_nmax;
            r_adp   <= r_dp[DP_W-1] ? ADP_W'(-r_dp) : ADP_W'(r_dp);
            r_deg6  <= (r_dp == '0);
        end
    end

    // stage 7: split products for numerator and denominator
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl   <= PL_W'(r_lmax6) * PL_W'(r_nmax[NHALF_W-1:0]);
            r_ph   <= PL_W'(r_lmax6) * PL_W'(r_nmax[N2_W-1:NHALF_W]);
            r_sl   <= PD_W'(r_adp[DHALF_W-1:0]) * PD_W'(r_adp[DHALF_W-1:0]);
            r_sm   <= PD_W'(r_adp[DHALF_W-1:0]) * PD_W'(r_adp[ADP_W-1:DHALF_W]);
            r_sh   <= PD_W'(r_adp[ADP_W-1:DHALF_W]) * PD_W'(r_adp[ADP_W-1:DHALF_W]);
            r_deg7 <= r_deg6;
        end
    end

    // stage 8: recombine partials, scale numerator to fixed point
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num8 <= (NUM_W'(r_pl) + (NUM_W'(r_ph) << NHALF_W)) << FRAC_BITS;
            r_den8 <= DEN_W'(r_sl) + (DEN_W'(r_sm) << (DHALF_W + 1))
                      + (DEN_W'(r_sh) << (2 * DHALF_W));
            r_deg8 <= r_deg7;
        end
    end

    // stage 9: quotient overflow check
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num9 <= r_num8;
            r_den9 <= r_den8;
            r_deg9 <= r_deg8;
            r_sat9 <= CMP_W'(r_num8 >> QUO_W) >= CMP_W'(r_den8);
        end
    end

    always_comb begin
        o_stage.valid = r_vld[NSTG-1];
        o_stage.sat   = r_sat9;
        o_stage.deg   = r_deg9;
        o_stage.rem   = r_num9;
        o_stage.den   = r_den9;
        o_stage.quo   = '0;
    end

endmodule

@@ design/tar_div_cell.sv @@
// one cell of the restoring divider row: decides one quotient bit
// depends on tar_pkg; chained in the top level
module tar_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  tar_pkg::t_div_stage i_stage,
    output tar_pkg::t_div_stage o_stage
);
    import tar_pkg::*;

    t_div_stage       r_stage;
    t_div_stage       n_stage;
    logic [CMP_W-1:0] w_trial;
    logic [CMP_W-1:0] w_diff;
    logic             w_ge;

    // trial subtract of the shifted divisor
    always_comb begin
        w_trial = CMP_W'(i_stage.den) << SHIFT;
        w_ge    = CMP_W'(i_stage.rem) >= w_trial;
        w_diff  = CMP_W'(i_stage.rem) - w_trial;
        n_stage = i_stage;
        if (w_ge) begin
            n_stage.rem = NUM_W'(w_diff);
            n_stage.quo = i_stage.quo | (QUO_W'(1) << SHIFT);
        end
    end

    // hand the item to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

@@ tb/tet_aspect_ratio_squared_core_tb.sv @@
// testbench for the tetrahedron squared aspect ratio core
// depends on tar_pkg and tet_aspect_ratio_squared_core; predicts each result
// with wide exact integers and checks it in order against the block's output
module tet_aspect_ratio_squared_core_tb;
    import tar_pkg::*;

    localparam int WDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 70;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_stall;
    t_tet_in  i_item = '0;
    logic     o_valid;
    logic     i_stall = 1'b0;
    t_tet_out o_item;

    t_tet_out ratio_q[$];
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       fail_count = 0;
    int       quiet_cycles = 0;

    tet_aspect_ratio_squared_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always #5 i_clk = ~i_clk;

    // exact squared aspect ratio of one tetrahedron
    function automatic t_tet_out tet_ratio_predict(input t_tet_in t);
        logic signed [255:0] p[4][3];
        logic signed [255:0] e1[3], e2[3], w[3], n[3], ev[3];
        logic signed [255:0] len, lmax, n2, nmax, dp;
        logic [255:0] num, den, quo;
        int o, s, u;
        t_tet_out r;
        for (int i = 0; i < 4; i++)
            for (int k = 0; k < 3; k++)
                p[i][k] = signed'(t[191 - 16 * (3 * i + k) -: 16]);
        lmax = 0;
        for (int i = 0; i < 3; i++)
            for (int j = i + 1; j < 4; j++) begin
                for (int k = 0; k < 3; k++) ev[k] = p[i][k] - p[j][k];
                len = ev[0] * ev[0] + ev[1] * ev[1] + ev[2] * ev[2];
                if (len > lmax) lmax = len;
            end
        nmax = 0;
        dp = 0;
        for (int i = 0; i < 4; i++) begin
            o = (i + 1) & 3;
            s = (i + 2) & 3;
            u = (i + 3) & 3;
            for (int k = 0; k < 3; k++) begin
                e1[k] = p[o][k] - p[s][k];
                e2[k] = p[o][k] - p[u][k];
                w[k]  = p[i][k] - p[o][k];
            end
            n[0] = e1[1] * e2[2] - e1[2] * e2[1];
            n[1] = e1[2] * e2[0] - e1[0] * e2[2];
            n[2] = e1[0] * e2[1] - e1[1] * e2[0];
            n2 = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
            if (n2 > nmax) nmax = n2;
            if (i == 0) dp = w[0] * n[0] + w[1] * n[1] + w[2] * n[2];
        end
        if (dp == 0) begin
            r.ratio_sq = RATIO_MAX;
            r.degenerate = 1'b1;
        end else begin
            num = (lmax * nmax) << FRAC_BITS;
            den = dp * dp;
            quo = num / den;
            r.ratio_sq = (quo >= (256'd1 << RATIO_W)) ? RATIO_MAX : quo[RATIO_W-1:0];
            r.degenerate = 1'b0;
        end
        return r;
    endfunction

    function automatic t_tet_in pack_tet(input logic [15:0] v[12]);
        return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
    endfunction

    // random tetrahedron, mostly well shaped with some flat and extreme ones
    function automatic t_tet_in random_tet();
        logic [15:0] v[12];
        int kind, spread;
        kind = $urandom_range(9);
        spread = ($urandom_range(2) == 0) ? 3 : (($urandom_range(1) == 0) ? 100 : 2000);
        for (int i = 0; i < 12; i++) v[i] = $urandom;
        if (kind >= 4 && kind <= 8) begin
            for (int i = 3; i < 12; i++)
                v[i] = v[i % 3] + 16'($urandom_range(2 * spread) - spread);
        end
        if (kind == 7)
            for (int k = 0; k < 3; k++) v[9 + k] = v[3 + k] + v[6 + k] - v[k];
        if (kind == 8)
            for (int k = 0; k < 3; k++) v[3 * $urandom_range(1, 3) + k] = v[k];
        if (kind == 9)
            for (int i = 0; i < 12; i++)
                case ($urandom_range(3))
                    0: v[i] = 16'h8000;
                    1: v[i] = 16'h7fff;
                    2: v[i] = 16'h0000;
                    default: v[i] = 16'hffff;
                endcase
        return pack_tet(v);
    endfunction

    // send one item, with random idle cycles ahead of it
    task automatic send_tet(input t_tet_in t);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= t;
        do @(posedge i_clk); while (o_stall);
        ratio_q.push_back(tet_ratio_predict(t));
    endtask

    // hold off the sender until every result is back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (ratio_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_coords(input int c[12]);
        logic [15:0] v[12];
        for (int i = 0; i < 12; i++) v[i] = 16'(c[i]);
        send_tet(pack_tet(v));
    endtask

    // directed shapes: regular, thin, flat, collapsed, extreme coordinates
    task automatic test_directed();
        send_coords('{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1});
        send_coords('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        send_coords('{1, 1, 1, 1, -1, -1, -1, 1, -1, -1, -1, 1});
        send_coords('{0, 0, 0, 32767, 0, 0, 0, 32767, 0, 0, 0, 1});
        send_coords('{-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0, 0, 0, 1});
        send_coords('{-32768, -32768, -32768, 32767, 32767, 32767,
                      -32768, 32767, -32768, 32767, -32768, -32768});
        send_coords('{-32768, -32768, -32768, 32767, -32768, -32768,
                      -32768, 32767, -32768, -32768, -32768, 32767});
        send_coords('{0, 0, 0, 1, 1, 1, 2, 2, 2, 5, -3, 7});
        send_coords('{0, 0, 0, 10, 0, 0, 0, 10, 0, 3, 4, 0});
        send_coords('{5, 5, 5, 5, 5, 5, 1, 2, 3, 4, 4, 9});
        send_coords('{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1});
        send_coords('{32767, 32767, 32767, -32768, -32768, -32768,
                      32767, -32768, 32767, 0, 0, 0});
        send_coords('{0, 0, 0, 32767, 0, 0, -32768, 1, 0, 0, 0, 1});
        send_coords('{100, 200, 300, 101, 200, 300, 100, 201, 300, 100, 200, 301});
    endtask

    task automatic test_random(input int count, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (count) send_tet(random_tet());
    endtask

    // receiver stall
    always @(posedge i_clk)
        i_stall <= ($urandom_range(99) < recv_stall_pct);

    // result checker
    always @(posedge i_clk) begin
        t_tet_out exp_item;
        if (i_rst_n && o_valid && !i_stall) begin
            if (ratio_q.size() == 0) begin
                $error("unexpected result item ratio_sq=%h", o_item.ratio_sq);
                fail_count++;
            end else begin
                exp_item = ratio_q.pop_front();
                if (o_item.ratio_sq !== exp_item.ratio_sq) begin
                    $error("ratio_sq expected %h actual %h",
                           exp_item.ratio_sq, o_item.ratio_sq);
                    fail_count++;
                end
                if (o_item.degenerate !== exp_item.degenerate) begin
                    $error("degenerate expected %b actual %b",
                           exp_item.degenerate, o_item.degenerate);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    initial begin
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        drain_results();
        test_random(100, 0, 0);
        test_random(100, 67, 0);
        drain_results();
        test_random(100, 0, 67);
        test_random(100, 14, 14);
        test_random(30, 0, 0);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && ratio_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
